// File: rtl/core/ihdp_pkg.sv
// Shared types and constants for the image header dimension parser.
// No dependencies; every module under rtl/core imports this package.
package ihdp_pkg;

  localparam int CNT_BITS_DEF = 32;
  localparam int HDR_BYTES    = 26;
  localparam int HDR_IDX_W    = $clog2(HDR_BYTES);

  // Result format codes
  localparam logic [2:0] FMT_PNG   = 3'd0;
  localparam logic [2:0] FMT_JPEG  = 3'd1;
  localparam logic [2:0] FMT_BMP   = 3'd2;
  localparam logic [2:0] FMT_GIF   = 3'd3;
  localparam logic [2:0] FMT_UNREC = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNREC = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // JPEG marker bytes
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_JPG    = 8'hC8;
  localparam logic [7:0] MK_DAC    = 8'hCC;

  // Signature bytes
  localparam logic [7:0] SIG_PNG0 = 8'h89;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_R = 8'h52;

  localparam logic [31:0] BMP_CORE_HDR = 32'd12;

  typedef enum logic [3:0] {
    PH_SCAN     = 4'd0,
    PH_MARK     = 4'd1,
    PH_LEN1_SOF = 4'd2,
    PH_LEN2_SOF = 4'd3,
    PH_LEN1_OTH = 4'd4,
    PH_LEN2_OTH = 4'd5,
    PH_PREC     = 4'd6,
    PH_H1       = 4'd7,
    PH_H2       = 4'd8,
    PH_W1       = 4'd9,
    PH_W2       = 4'd10,
    PH_SKIP     = 4'd11,
    PH_FOUND    = 4'd12
  } phase_t;

  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
  } jpeg_res_t;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_arr_t;

endpackage

// File: rtl/core/ihdp_jpeg_walk.sv
// JPEG marker walk: tracks segments byte by byte and captures the first SOF size.
// Depends on ihdp_pkg (phase_t, jpeg_res_t, marker constants).
module ihdp_jpeg_walk
  import ihdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       clear,
  input  logic [7:0] data_byte,
  output jpeg_res_t  res
);

  phase_t      phase_r, phase_nxt;
  logic        stop_r, stop_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] fw_r, fw_nxt;
  logic [15:0] fh_r, fh_nxt;

  logic        go;
  logic        standalone;
  logic        is_sof;
  logic        short_len;
  logic [15:0] seg_len;

  assign go = step && !stop_r;
  assign standalone = (data_byte == MK_TEM) || (data_byte == MK_SOI) ||
                      (data_byte[7:3] == 5'b11010);
  assign is_sof = (data_byte[7:4] == 4'hC) && (data_byte != MK_DHT) &&
                  (data_byte != MK_JPG) && (data_byte != MK_DAC);
  assign seg_len   = {len_hi_r, data_byte};
  assign short_len = (seg_len < 16'd2);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      unique case (phase_r)
        PH_SCAN: begin
          if (data_byte == MK_PREFIX) phase_nxt = PH_MARK;
        end
        PH_MARK: begin
          priority if (data_byte == MK_PREFIX) phase_nxt = PH_MARK;
          else if (standalone) phase_nxt = PH_SCAN;
          else if (data_byte == MK_EOI || data_byte == MK_SOS) phase_nxt = PH_MARK;
          else if (is_sof) phase_nxt = PH_LEN1_SOF;
          else phase_nxt = PH_LEN1_OTH;
        end
        PH_LEN1_SOF: phase_nxt = PH_LEN2_SOF;
        PH_LEN1_OTH: phase_nxt = PH_LEN2_OTH;
        PH_LEN2_SOF: begin
          if (!short_len) phase_nxt = PH_PREC;
        end
        PH_LEN2_OTH: begin
          if (!short_len) phase_nxt = (seg_len == 16'd2) ? PH_SCAN : PH_SKIP;
        end
        PH_PREC: phase_nxt = PH_H1;
        PH_H1:   phase_nxt = PH_H2;
        PH_H2:   phase_nxt = PH_W1;
        PH_W1:   phase_nxt = PH_W2;
        PH_W2:   phase_nxt = PH_FOUND;
        PH_SKIP: begin
          if (skip_r <= 16'd1) phase_nxt = PH_SCAN;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Datapath registers and stop flag
  always_comb begin
    stop_nxt   = stop_r;
    len_hi_nxt = len_hi_r;
    skip_nxt   = skip_r;
    fw_nxt     = fw_r;
    fh_nxt     = fh_r;
    if (go) begin
      unique case (phase_r)
        PH_SCAN: ;
        PH_MARK: begin
          if (data_byte == MK_EOI || data_byte == MK_SOS) stop_nxt = 1'b1;
        end
        PH_LEN1_SOF, PH_LEN1_OTH: len_hi_nxt = data_byte;
        PH_LEN2_SOF: begin
          if (short_len) stop_nxt = 1'b1;
        end
        PH_LEN2_OTH: begin
          if (short_len) stop_nxt = 1'b1;
          else skip_nxt = seg_len - 16'd2;
        end
        PH_PREC: ;
        PH_H1: fh_nxt = {data_byte, 8'h00};
        PH_H2: fh_nxt = {fh_r[15:8], data_byte};
        PH_W1: fw_nxt = {data_byte, 8'h00};
        PH_W2: begin
          fw_nxt   = {fw_r[15:8], data_byte};
          stop_nxt = 1'b1;
        end
        PH_SKIP: begin
          if (skip_r != 16'd0) skip_nxt = skip_r - 16'd1;
        end
        default: stop_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r  <= PH_SCAN;
      stop_r   <= 1'b0;
      len_hi_r <= '0;
      skip_r   <= '0;
      fw_r     <= '0;
      fh_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      stop_r   <= stop_nxt;
      len_hi_r <= len_hi_nxt;
      skip_r   <= skip_nxt;
      fw_r     <= fw_nxt;
      fh_r     <= fh_nxt;
    end
  end

  // Report the walk as it stands after the current byte
  assign res.found  = (phase_nxt == PH_FOUND);
  assign res.width  = fw_nxt;
  assign res.height = fh_nxt;

endmodule

// File: rtl/core/ihdp_decode.sv
// Format detection and dimension decode from the stored header bytes.
// Depends on ihdp_pkg (hdr_arr_t, jpeg_res_t, format/status codes).
module ihdp_decode
  import ihdp_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  hdr_arr_t               hdr,
  input  logic [COUNT_BITS-1:0]  len,
  input  jpeg_res_t              jpeg,
  output logic [2:0]             format,
  output logic [1:0]             status,
  output logic [30:0]            image_width,
  output logic [30:0]            image_height
);

  logic        is_png, is_jpeg, is_bmp, is_gif;
  logic        bad;
  logic [31:0] w, h;
  logic [31:0] bmp_w32, bmp_h32;
  logic [15:0] bmp_w16, bmp_h16;
  logic [31:0] mag_w32, mag_h32, mag_w16, mag_h16;

  assign is_png  = (len >= COUNT_BITS'(8)) && hdr[0] == SIG_PNG0 && hdr[1] == CH_P &&
                   hdr[2] == CH_N && hdr[3] == CH_G;
  assign is_jpeg = (len >= COUNT_BITS'(2)) && hdr[0] == MK_PREFIX && hdr[1] == MK_SOI;
  assign is_bmp  = (len >= COUNT_BITS'(2)) && hdr[0] == CH_B && hdr[1] == CH_M;
  assign is_gif  = (len >= COUNT_BITS'(10)) && hdr[0] == CH_G && hdr[1] == CH_I &&
                   hdr[2] == CH_F;

  assign bmp_w16 = {hdr[19], hdr[18]};
  assign bmp_h16 = {hdr[21], hdr[20]};
  assign bmp_w32 = {hdr[21], hdr[20], hdr[19], hdr[18]};
  assign bmp_h32 = {hdr[25], hdr[24], hdr[23], hdr[22]};

  // Take magnitudes of the signed BMP fields
  assign mag_w16 = bmp_w16[15] ? 32'h0001_0000 - {16'h0, bmp_w16} : {16'h0, bmp_w16};
  assign mag_h16 = bmp_h16[15] ? 32'h0001_0000 - {16'h0, bmp_h16} : {16'h0, bmp_h16};
  assign mag_w32 = bmp_w32[31] ? (~bmp_w32 + 32'd1) : bmp_w32;
  assign mag_h32 = bmp_h32[31] ? (~bmp_h32 + 32'd1) : bmp_h32;

  always_comb begin
    format = FMT_UNREC;
    bad    = 1'b0;
    w      = '0;
    h      = '0;
    priority if (is_png) begin
      format = FMT_PNG;
      if (len >= COUNT_BITS'(24) && hdr[12] == CH_I && hdr[13] == CH_H &&
          hdr[14] == CH_D && hdr[15] == CH_R) begin
        w   = {hdr[16], hdr[17], hdr[18], hdr[19]};
        h   = {hdr[20], hdr[21], hdr[22], hdr[23]};
        bad = w[31] || h[31];
      end
    end else if (is_jpeg) begin
      format = FMT_JPEG;
      if (jpeg.found) begin
        w = {16'h0, jpeg.width};
        h = {16'h0, jpeg.height};
      end
    end else if (is_bmp) begin
      format = FMT_BMP;
      if (len >= COUNT_BITS'(22)) begin
        if ({hdr[17], hdr[16], hdr[15], hdr[14]} == BMP_CORE_HDR) begin
          w = mag_w16;
          h = mag_h16;
        end else if (len >= COUNT_BITS'(26)) begin
          w   = mag_w32;
          h   = mag_h32;
          bad = (bmp_w32 == 32'h8000_0000) || (bmp_h32 == 32'h8000_0000);
        end
      end
    end else if (is_gif) begin
      format = FMT_GIF;
      w = {16'h0, hdr[7], hdr[6]};
      h = {16'h0, hdr[9], hdr[8]};
    end else begin
      format = FMT_UNREC;
    end
  end

  always_comb begin
    image_width  = '0;
    image_height = '0;
    if (format == FMT_UNREC) begin
      status = ST_UNREC;
    end else if (bad || w == 32'd0 || h == 32'd0) begin
      status = ST_BAD;
    end else begin
      status       = ST_OK;
      image_width  = w[30:0];
      image_height = h[30:0];
    end
  end

endmodule

// File: rtl/core/image_header_dimension_parser.sv
// Image header dimension parser: takes a file one byte per request (is_last on the final
// byte) and returns one result per file: format, status and width/height. A byte is
// accepted every clock while no final byte is held; each byte passes an input register,
// then the header-store, counter and JPEG marker-walk update, and the final byte's result
// is decoded from these and lands in the output register once that register is free. The
// walk update keeps the rate at one byte per clock. in_ready drops only while a final-byte
// request waits behind a result not yet taken. After the final byte the parser is back in
// its reset state. Depends on ihdp_pkg, ihdp_jpeg_walk and ihdp_decode.
module image_header_dimension_parser
  import ihdp_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_format,
  output logic [1:0]  out_status,
  output logic [30:0] out_image_width,
  output logic [30:0] out_image_height
);

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_last_r;
  logic                  s1_adv;
  logic                  finish;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  hdr_arr_t              hdr_r, hdr_view;
  jpeg_res_t             jpeg;

  logic [2:0]            dec_format;
  logic [1:0]            dec_status;
  logic [30:0]           dec_w, dec_h;

  logic                  out_valid_r;
  logic [2:0]            out_format_r;
  logic [1:0]            out_status_r;
  logic [30:0]           out_w_r, out_h_r;

  // A final byte holds only while the output register is still occupied
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign finish   = s1_adv && s1_last_r;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_is_last;
    end
  end

  // Saturating byte count
  assign cnt_inc = (cnt_r == {COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + COUNT_BITS'(1);
  assign cnt_nxt = !s1_adv ? cnt_r : (s1_last_r ? '0 : cnt_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && cnt_r < COUNT_BITS'(HDR_BYTES)) begin
      hdr_r[cnt_r[HDR_IDX_W-1:0]] <= s1_byte_r;
    end
  end

  // Header as it stands with the current byte written
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_view[i] = (cnt_r == COUNT_BITS'(i)) ? s1_byte_r : hdr_r[i];
    end
  end

  ihdp_jpeg_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv && cnt_r >= COUNT_BITS'(2)),
    .clear     (finish),
    .data_byte (s1_byte_r),
    .res       (jpeg)
  );

  ihdp_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .hdr          (hdr_view),
    .len          (cnt_inc),
    .jpeg         (jpeg),
    .format       (dec_format),
    .status       (dec_status),
    .image_width  (dec_w),
    .image_height (dec_h)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_format_r <= dec_format;
      out_status_r <= dec_status;
      out_w_r      <= dec_w;
      out_h_r      <= dec_h;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_format       = out_format_r;
  assign out_status       = out_status_r;
  assign out_image_width  = out_w_r;
  assign out_image_height = out_h_r;

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |-> out_w_r != '0 && out_h_r != '0)
    else $error("ok result with a zero dimension");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_w_r == '0 && out_h_r == '0)
    else $error("failed result carries dimensions");

  a_unrec_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_format_r == FMT_UNREC) == (out_status_r == ST_UNREC)))
    else $error("format and status disagree on recognition");

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> cnt_r == '0)
    else $error("byte count not cleared after final byte");

endmodule
